// File: hdl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Types, constants and the gray-level class table for the frame pixel
// statistics unit.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam logic [8:0] LINE_WIDTH  = 9'd256;
    localparam logic [8:0] FRAME_LINES = 9'd240;

    localparam logic [8:0]  NEG_ONE_9  = 9'h1ff;
    localparam logic [15:0] CNT16_MAX  = 16'hffff;
    localparam logic [31:0] CNT32_MAX  = 32'hffff_ffff;
    localparam logic [7:0]  INDEX_MAX  = 8'hff;
    localparam logic [7:0]  INDEX_MIN  = 8'h00;

    typedef enum logic [1:0] {
        CLS_BLACK  = 2'd0,
        CLS_GRAY   = 2'd1,
        CLS_BRIGHT = 2'd2
    } class_t;

    // class per six-bit colour, levels rising from black to white
    localparam logic [1:0] LEVEL_CLASS [64] = '{
        2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1
    };

    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] col;
        logic [7:0] row;
        logic       frame_end;
    } pix_t;

    typedef struct packed {
        logic [15:0] nonzero_count;
        logic [15:0] nonblack_count;
        logic [15:0] bright_count;
        logic [15:0] gray_count;
        logic [7:0]  min_index;
        logic [7:0]  max_index;
        logic [6:0]  unique_colors;
        logic [8:0]  first_x;
        logic [8:0]  first_y;
        logic [31:0] visible_frames;
    } result_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == CNT16_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// File: hdl/fps_core.sv
// ----------------------------------------------------------------------------
// fps_core
// Per-frame accumulators. Folds one pixel per step and presents the frame
// result that includes the pixel being folded.
// ----------------------------------------------------------------------------
module fps_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  fps_pkg::pix_t    pix,
    output fps_pkg::result_t result
);

    logic [63:0] seen_reg,     seen_next;
    logic [6:0]  unique_reg,   unique_next;
    logic [15:0] nonzero_reg,  nonzero_next;
    logic [15:0] nonblack_reg, nonblack_next;
    logic [15:0] bright_reg,   bright_next;
    logic [15:0] gray_reg,     gray_next;
    logic [7:0]  min_reg,      min_next;
    logic [7:0]  max_reg,      max_next;
    logic [8:0]  first_col_reg, first_col_next;
    logic [8:0]  first_row_reg, first_row_next;
    logic [31:0] visible_reg,  visible_next;

    logic            in_win;
    logic [5:0]      colour;
    fps_pkg::class_t cls;

    assign colour = pix.pixel[5:0];
    assign cls    = fps_pkg::class_t'(fps_pkg::LEVEL_CLASS[colour]);
    assign in_win = ({1'b0, pix.col} < fps_pkg::LINE_WIDTH) &&
                    ({1'b0, pix.row} < fps_pkg::FRAME_LINES);

    always_comb begin
        seen_next      = seen_reg;
        unique_next    = unique_reg;
        nonzero_next   = nonzero_reg;
        nonblack_next  = nonblack_reg;
        bright_next    = bright_reg;
        gray_next      = gray_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        first_col_next = first_col_reg;
        first_row_next = first_row_reg;
        if (in_win) begin
            seen_next[colour] = 1'b1;
            if (!seen_reg[colour]) begin
                unique_next = unique_reg + 7'd1;
            end
            if (pix.pixel != fps_pkg::INDEX_MIN) begin
                nonzero_next = fps_pkg::sat_inc16(nonzero_reg);
            end
            if (pix.pixel < min_reg) begin
                min_next = pix.pixel;
            end
            if (pix.pixel > max_reg) begin
                max_next = pix.pixel;
            end
            if (cls != fps_pkg::CLS_BLACK) begin
                nonblack_next = fps_pkg::sat_inc16(nonblack_reg);
                if (first_col_reg == fps_pkg::NEG_ONE_9) begin
                    first_col_next = {1'b0, pix.col};
                    first_row_next = {1'b0, pix.row};
                end
            end
            case (cls)
                fps_pkg::CLS_BRIGHT: bright_next = fps_pkg::sat_inc16(bright_reg);
                fps_pkg::CLS_GRAY:   gray_next   = fps_pkg::sat_inc16(gray_reg);
                default: ;
            endcase
        end
        visible_next = visible_reg;
        if (nonblack_next != 16'd0 && visible_reg != fps_pkg::CNT32_MAX) begin
            visible_next = visible_reg + 32'd1;
        end
    end

    always_comb begin
        result.nonzero_count  = nonzero_next;
        result.nonblack_count = nonblack_next;
        result.bright_count   = bright_next;
        result.gray_count     = gray_next;
        result.min_index      = (min_next == fps_pkg::INDEX_MAX) ? fps_pkg::INDEX_MIN
                                                                 : min_next;
        result.max_index      = max_next;
        result.unique_colors  = unique_next;
        result.first_x        = first_col_next;
        result.first_y        = first_row_next;
        result.visible_frames = visible_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && pix.frame_end)) begin
            seen_reg      <= '0;
            unique_reg    <= '0;
            nonzero_reg   <= '0;
            nonblack_reg  <= '0;
            bright_reg    <= '0;
            gray_reg      <= '0;
            min_reg       <= fps_pkg::INDEX_MAX;
            max_reg       <= fps_pkg::INDEX_MIN;
            first_col_reg <= fps_pkg::NEG_ONE_9;
            first_row_reg <= fps_pkg::NEG_ONE_9;
        end else if (step) begin
            seen_reg      <= seen_next;
            unique_reg    <= unique_next;
            nonzero_reg   <= nonzero_next;
            nonblack_reg  <= nonblack_next;
            bright_reg    <= bright_next;
            gray_reg      <= gray_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            first_col_reg <= first_col_next;
            first_row_reg <= first_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visible_reg <= '0;
        end else if (step && pix.frame_end) begin
            visible_reg <= visible_next;
        end
    end

endmodule

// File: hdl/frame_pixel_statistics_unit.sv
// ----------------------------------------------------------------------------
// frame_pixel_statistics_unit
// Per-frame pixel statistics over a stream of palette-index pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one pixel per transaction, s_tdata = {row, col, pixel},
//   s_tlast marks the last pixel of the frame.
//   m_ channel: one result transaction per frame, issued for the s_tlast
//   pixel; no transaction for any other pixel.
//   Throughput: one pixel per cycle, unless a last pixel waits on a held
//   result; the core is combinational between the input and result registers.
//   The result register loads when the last pixel leaves the input
//   register, and m_tvalid is driven from the result register.
//   Reset (aresetn low, synchronous) empties both registers and clears all
//   accumulators, including the visible frame count.
//   When the receiver stalls, the result is held on m_tdata; ordinary
//   pixels keep flowing and only a further last pixel waits, at which
//   point s_tready drops until the held result is taken.
// ----------------------------------------------------------------------------
module frame_pixel_statistics_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // pixel[7:0], col[15:8], row[23:16]
    input  logic         s_tlast,   // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // nonzero_count[15:0], nonblack_count[31:16],
                                    // bright_count[47:32], gray_count[63:48],
                                    // min_index[71:64], max_index[79:72],
                                    // unique_colors[86:80], first_x[95:87],
                                    // first_y[104:96], visible_frames[136:105],
                                    // zero[143:137]
);

    logic             in_valid_reg;
    fps_pkg::pix_t    in_pix_reg;
    logic             out_valid_reg;
    fps_pkg::result_t out_res_reg;
    fps_pkg::result_t core_res;
    logic             out_free;
    logic             fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_pix_reg.frame_end || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pix_reg.pixel     <= s_tdata[7:0];
            in_pix_reg.col       <= s_tdata[15:8];
            in_pix_reg.row       <= s_tdata[23:16];
            in_pix_reg.frame_end <= s_tlast;
        end
    end

    fps_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .pix     (in_pix_reg),
        .result  (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_pix_reg.frame_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_pix_reg.frame_end) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_res_reg.visible_frames,
                       out_res_reg.first_y,
                       out_res_reg.first_x,
                       out_res_reg.unique_colors,
                       out_res_reg.max_index,
                       out_res_reg.min_index,
                       out_res_reg.gray_count,
                       out_res_reg.bright_count,
                       out_res_reg.nonblack_count,
                       out_res_reg.nonzero_count};

endmodule

// File: hdl/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks for the frame pixel statistics unit, bound to the top.
// ----------------------------------------------------------------------------
module fps_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    logic [15:0] nonblack;
    logic [16:0] class_sum;

    assign nonblack  = m_tdata[31:16];
    assign class_sum = {1'b0, m_tdata[47:32]} + {1'b0, m_tdata[63:48]};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_class_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (nonblack != 16'hffff) |-> class_sum == {1'b0, nonblack})
        else $error("bright plus gray differs from nonblack");

    a_first_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[95:87] == 9'h1ff) == (nonblack == 16'd0)))
        else $error("first position disagrees with nonblack count");

    a_min_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[71:64] <= m_tdata[79:72])
        else $error("minimum above maximum");

endmodule

bind frame_pixel_statistics_unit fps_checker u_fps_checker (.*);

// File: tb/frame_pixel_statistics_unit_tb.sv
// ----------------------------------------------------------------------------
// frame_pixel_statistics_unit_tb
// Self-checking bench for the frame pixel statistics unit. Pixels are streamed
// in as frames of random length and content. A scoreboard keeps its own
// running frame statistics and checks each result transaction against them.
// The sender and the receiver are paced through several idling phases.
// ----------------------------------------------------------------------------
module frame_pixel_statistics_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CYCLE_LIMIT = 1_000_000;

    typedef enum int {
        FRAME_MIXED,
        FRAME_DARK,
        FRAME_OUTSIDE
    } frame_kind_t;

    class frame_stats_board;
        logic [63:0]      colours_seen;
        logic [15:0]      nonzero_n;
        logic [15:0]      nonblack_n;
        logic [15:0]      bright_n;
        logic [15:0]      gray_n;
        logic [7:0]       lowest_index;
        logic [7:0]       highest_index;
        logic [8:0]       first_col;
        logic [8:0]       first_row;
        logic [31:0]      visible_n;
        fps_pkg::result_t pending_stats[$];
        int unsigned      mismatches;
        int unsigned      frames_checked;
        int unsigned      pixels_taken;

        function new();
            visible_n      = '0;
            mismatches     = 0;
            frames_checked = 0;
            pixels_taken   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            colours_seen  = '0;
            nonzero_n     = '0;
            nonblack_n    = '0;
            bright_n      = '0;
            gray_n        = '0;
            lowest_index  = fps_pkg::INDEX_MAX;
            highest_index = fps_pkg::INDEX_MIN;
            first_col     = fps_pkg::NEG_ONE_9;
            first_row     = fps_pkg::NEG_ONE_9;
        endfunction

        function logic [15:0] bump16(input logic [15:0] v);
            return (v == fps_pkg::CNT16_MAX) ? v : v + 16'd1;
        endfunction

        function int unsigned pending();
            return pending_stats.size();
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t: %s", $realtime, msg);
            end
        endfunction

        function void take_pixel(input fps_pkg::pix_t p);
            logic [1:0]       cls;
            fps_pkg::result_t r;
            pixels_taken++;
            if ({1'b0, p.col} < fps_pkg::LINE_WIDTH &&
                {1'b0, p.row} < fps_pkg::FRAME_LINES) begin
                cls = fps_pkg::LEVEL_CLASS[p.pixel[5:0]];
                colours_seen[p.pixel[5:0]] = 1'b1;
                if (p.pixel != 8'd0) begin
                    nonzero_n = bump16(nonzero_n);
                end
                if (p.pixel < lowest_index) begin
                    lowest_index = p.pixel;
                end
                if (p.pixel > highest_index) begin
                    highest_index = p.pixel;
                end
                if (cls != fps_pkg::CLS_BLACK) begin
                    nonblack_n = bump16(nonblack_n);
                    if (first_col == fps_pkg::NEG_ONE_9) begin
                        first_col = {1'b0, p.col};
                        first_row = {1'b0, p.row};
                    end
                end
                if (cls == fps_pkg::CLS_BRIGHT) begin
                    bright_n = bump16(bright_n);
                end else if (cls == fps_pkg::CLS_GRAY) begin
                    gray_n = bump16(gray_n);
                end
            end
            if (!p.frame_end) begin
                return;
            end
            if (nonblack_n != 16'd0 && visible_n != fps_pkg::CNT32_MAX) begin
                visible_n = visible_n + 32'd1;
            end
            r.nonzero_count  = nonzero_n;
            r.nonblack_count = nonblack_n;
            r.bright_count   = bright_n;
            r.gray_count     = gray_n;
            r.min_index      = (lowest_index == fps_pkg::INDEX_MAX) ? fps_pkg::INDEX_MIN
                                                                    : lowest_index;
            r.max_index      = highest_index;
            r.unique_colors  = 7'($countones(colours_seen));
            r.first_x        = first_col;
            r.first_y        = first_row;
            r.visible_frames = visible_n;
            pending_stats.push_back(r);
            clear_frame();
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] seen);
            if (seen !== want) begin
                flag($sformatf("frame %0d %s: expected %0h, got %0h",
                               frames_checked, name, want, seen));
            end
        endfunction

        function void check_stats(input logic [143:0] d);
            fps_pkg::result_t want;
            if (pending_stats.size() == 0) begin
                flag($sformatf("unexpected result transaction %0h", d));
                return;
            end
            want = pending_stats.pop_front();
            compare_field("nonzero_count",  32'(want.nonzero_count),  32'(d[15:0]));
            compare_field("nonblack_count", 32'(want.nonblack_count), 32'(d[31:16]));
            compare_field("bright_count",   32'(want.bright_count),   32'(d[47:32]));
            compare_field("gray_count",     32'(want.gray_count),     32'(d[63:48]));
            compare_field("min_index",      32'(want.min_index),      32'(d[71:64]));
            compare_field("max_index",      32'(want.max_index),      32'(d[79:72]));
            compare_field("unique_colors",  32'(want.unique_colors),  32'(d[86:80]));
            compare_field("first_x",        32'(want.first_x),        32'(d[95:87]));
            compare_field("first_y",        32'(want.first_y),        32'(d[104:96]));
            compare_field("visible_frames", want.visible_frames,      d[136:105]);
            compare_field("padding",        32'd0,                    32'(d[143:137]));
            frames_checked++;
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata  = '0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    frame_stats_board board;
    int unsigned      send_idle_pct = 0;
    int unsigned      stall_pct     = 0;
    longint unsigned  cycle_count   = 0;

    frame_pixel_statistics_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                board.check_stats(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                board.take_pixel('{pixel: s_tdata[7:0], col: s_tdata[15:8],
                                   row: s_tdata[23:16], frame_end: s_tlast});
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("frame_pixel_statistics_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] pixel, input logic [7:0] col,
                              input logic [7:0] row, input logic frame_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col, pixel};
        s_tlast  <= frame_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic fps_pkg::pix_t random_pixel(input frame_kind_t kind);
        fps_pkg::pix_t p;
        p.pixel = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: p.pixel = 8'h00;
            1: p.pixel = 8'hff;
            2: p.pixel = {2'($urandom_range(0, 3)), 6'($urandom_range(1, 15))};
            default: ;
        endcase
        if (kind == FRAME_DARK) begin
            p.pixel = {2'($urandom_range(0, 3)), 6'($urandom_range(1, 15))};
        end
        p.col = 8'($urandom_range(0, 255));
        if (kind == FRAME_OUTSIDE || $urandom_range(0, 15) == 0) begin
            p.row = 8'($urandom_range(240, 255));
        end else begin
            p.row = 8'($urandom_range(0, 239));
        end
        p.frame_end = 1'b0;
        return p;
    endfunction

    task automatic send_frames(input int unsigned n_pixels);
        int unsigned   sent;
        int unsigned   len;
        int unsigned   pick;
        frame_kind_t   kind;
        fps_pkg::pix_t p;
        sent = 0;
        while (sent < n_pixels) begin
            pick = $urandom_range(0, 19);
            kind = (pick < 2) ? FRAME_DARK : (pick < 3) ? FRAME_OUTSIDE : FRAME_MIXED;
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 30);
            for (int i = 0; i < len; i++) begin
                p = random_pixel(kind);
                send_pixel(p.pixel, p.col, p.row, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames, no idling
        send_pixel(8'h00, 8'd0,   8'd0,   1'b0);
        send_pixel(8'hff, 8'd255, 8'd239, 1'b0);
        send_pixel(8'h01, 8'd17,  8'd4,   1'b0);
        send_pixel(8'h10, 8'd18,  8'd4,   1'b1);
        send_pixel(8'h30, 8'd5,   8'd240, 1'b1);   // empty frame
        send_pixel(8'h0d, 8'd1,   8'd1,   1'b0);   // dark only
        send_pixel(8'hc1, 8'd2,   8'd1,   1'b1);
        send_pixel(8'h30, 8'd0,   8'd255, 1'b0);   // outside window
        send_pixel(8'h2e, 8'd128, 8'd100, 1'b1);
        send_pixel(8'hff, 8'd9,   8'd9,   1'b1);   // minimum ff is reported as 00
        send_pixel(8'h05, 8'd3,   8'd2,   1'b0);
        send_pixel(8'h14, 8'd7,   8'd2,   1'b0);
        send_pixel(8'h20, 8'd0,   8'd5,   1'b1);
        send_pixel(8'h15, 8'd44,  8'd60,  1'b0);
        send_pixel(8'h3f, 8'd45,  8'd250, 1'b1);   // closing pixel outside window
        send_pixel(8'h7e, 8'd255, 8'd0,   1'b0);
        send_pixel(8'h8f, 8'd0,   8'd239, 1'b0);
        send_pixel(8'h40, 8'd100, 8'd200, 1'b1);

        send_frames(450);
        send_idle_pct = 85;
        send_frames(450);
        send_idle_pct = 0;
        stall_pct     = 85;
        send_frames(450);
        send_idle_pct = 23;
        stall_pct     = 23;
        send_frames(450);
        s_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d pixels streamed, %0d frame results checked", board.pixels_taken,
                 board.frames_checked);
        $display("idling phases: none, sender, receiver, both");
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("frame_pixel_statistics_unit_tb: done, clean");
        end else begin
            $display("frame_pixel_statistics_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
